FILE: rtl/matrix_display_serial_command_sender_top_macros.svh
// Assertion macros shared by the serial command sender modules.
`ifndef MATRIX_DISPLAY_SERIAL_COMMAND_SENDER_TOP_MACROS_SVH
`define MATRIX_DISPLAY_SERIAL_COMMAND_SENDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MDSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define MDSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mdss_pkg.sv
// Types, constants and helpers shared by the serial command sender.
`timescale 1ns / 1ps
package mdss_pkg;

    localparam int ROWS_PER_GLYPH = 7;
    localparam int ROW_FIELDS     = 7;
    localparam int BYTES_MAX      = ROWS_PER_GLYPH + 1;
    localparam int LIST_AW        = (BYTES_MAX > 1) ? $clog2(BYTES_MAX) : 1;
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

    localparam int CMD_W    = 3;
    localparam int DIGIT_W  = 8;
    localparam int ROW_W    = 5;
    localparam int BRIGHT_W = 8;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 8;

    localparam logic [CMD_W-1:0] CMD_GLYPH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BRIGHT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEAK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;

    localparam logic [CFG_IW-1:0] REG_INIT_BRIGHT = 1'b0;
    localparam logic [CFG_IW-1:0] REG_INIT_PEAK   = 1'b1;

    localparam logic [7:0]         CTRL_BASE       = 8'b1100_0000;
    localparam logic [7:0]         ADDR_BASE       = 8'b1010_0000;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX       = 8'd7;
    localparam logic [LEVEL_W-1:0] INIT_BRIGHT_RST = 3'd7;
    localparam logic               INIT_PEAK_RST   = 1'b0;

    // One byte waiting for the serializer, with its readback values.
    typedef struct packed {
        logic [7:0]         data;
        logic               last;
        logic [LEVEL_W-1:0] level;
        logic               peak;
    } t_byte_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [LEVEL_W-1:0] bright;
        logic               low_peak;
    } t_init_cfg;

    // Control byte: bit 5 set when clear is off, bit 4 peak, bits 2..0 level field.
    function automatic logic [7:0] ctrl_byte(input logic clr, input logic pk,
                                             input logic [LEVEL_W-1:0] lvl);
        return CTRL_BASE | {2'b00, ~clr, pk, 1'b0, lvl};
    endfunction

endpackage

FILE: rtl/mdss_ifs.sv
// Valid/ready channel interfaces for commands, serial bits and configuration.
`timescale 1ns / 1ps
interface mdss_in_if;
    logic                                valid;
    logic                                ready;
    logic [mdss_pkg::CMD_W-1:0]          command;
    logic [mdss_pkg::DIGIT_W-1:0]        digit;
    logic [mdss_pkg::ROW_W-1:0]          row0;
    logic [mdss_pkg::ROW_W-1:0]          row1;
    logic [mdss_pkg::ROW_W-1:0]          row2;
    logic [mdss_pkg::ROW_W-1:0]          row3;
    logic [mdss_pkg::ROW_W-1:0]          row4;
    logic [mdss_pkg::ROW_W-1:0]          row5;
    logic [mdss_pkg::ROW_W-1:0]          row6;
    logic [mdss_pkg::BRIGHT_W-1:0]       brightness;
    logic                                low_peak;

    modport source (output valid, command, digit, row0, row1, row2, row3, row4, row5,
                    row6, brightness, low_peak, input ready);
    modport sink   (input valid, command, digit, row0, row1, row2, row3, row4, row5,
                    row6, brightness, low_peak, output ready);
endinterface

interface mdss_out_if;
    logic                           valid;
    logic                           ready;
    logic                           data_bit;
    logic                           byte_end;
    logic                           last;
    logic [mdss_pkg::LEVEL_W-1:0]   level_now;
    logic                           peak_now;

    modport source (output valid, data_bit, byte_end, last, level_now, peak_now,
                    input ready);
    modport sink   (input valid, data_bit, byte_end, last, level_now, peak_now,
                    output ready);
endinterface

interface mdss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mdss_pkg::CFG_IW-1:0]   index;
    logic [mdss_pkg::CFG_DW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mdss_fifo.sv
// Short byte queue between the command front end and the serializer.
`timescale 1ns / 1ps
`include "matrix_display_serial_command_sender_top_macros.svh"
module mdss_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mdss_pkg::t_byte_entry i_data,
    input  logic                  i_pop,
    output mdss_pkg::t_byte_entry o_data,
    output mdss_pkg::t_q_status   o_stat
);
    localparam logic [mdss_pkg::FIFO_AW:0] DEPTH_C =
        (mdss_pkg::FIFO_AW+1)'(mdss_pkg::FIFO_DEPTH);

    mdss_pkg::t_byte_entry          r_mem [mdss_pkg::FIFO_DEPTH];
    logic [mdss_pkg::FIFO_AW-1:0]   r_wp;
    logic [mdss_pkg::FIFO_AW-1:0]   r_rp;
    logic [mdss_pkg::FIFO_AW:0]     r_cnt;
    logic [mdss_pkg::FIFO_AW:0]     n_cnt;

    assign o_stat.full  = (r_cnt == DEPTH_C);
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `MDSS_ASSERT_IMP(a_no_push_full, i_push, !o_stat.full, "push into full queue")
    `MDSS_ASSERT_IMP(a_no_pop_empty, i_pop, !o_stat.empty, "pop from empty queue")
    `MDSS_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= DEPTH_C, "queue count beyond depth")

endmodule

FILE: rtl/mdss_front.sv
// Command front end: decodes a command, updates the mirror, queues its bytes.
`timescale 1ns / 1ps
module mdss_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mdss_in_if.sink               i_in,
    input  mdss_pkg::t_init_cfg   i_init,
    input  mdss_pkg::t_q_status   i_qstat,
    output logic                  o_push,
    output mdss_pkg::t_byte_entry o_entry
);
    logic [mdss_pkg::ROW_W-1:0]     w_rows [mdss_pkg::ROW_FIELDS];
    logic [7:0]                     n_list [mdss_pkg::BYTES_MAX];
    logic [7:0]                     r_list [mdss_pkg::BYTES_MAX];
    logic [mdss_pkg::LIST_AW:0]     n_cnt;
    logic [mdss_pkg::LIST_AW-1:0]   r_idx;
    logic [mdss_pkg::LIST_AW-1:0]   r_last_idx;
    logic                           r_busy;
    logic                           r_peak;
    logic [mdss_pkg::LEVEL_W-1:0]   r_level;
    logic                           n_peak;
    logic [mdss_pkg::LEVEL_W-1:0]   n_level;
    logic                           w_accept;
    logic                           w_last;

    assign w_rows[0] = i_in.row0;
    assign w_rows[1] = i_in.row1;
    assign w_rows[2] = i_in.row2;
    assign w_rows[3] = i_in.row3;
    assign w_rows[4] = i_in.row4;
    assign w_rows[5] = i_in.row5;
    assign w_rows[6] = i_in.row6;

    assign i_in.ready = !r_busy;
    assign w_accept   = i_in.valid && !r_busy;
    assign w_last     = (r_idx == r_last_idx);
    assign o_push     = r_busy && !i_qstat.full;

    assign o_entry.data  = r_list[r_idx];
    assign o_entry.last  = w_last;
    assign o_entry.level = ~r_level;
    assign o_entry.peak  = r_peak;

    // Build the byte list and the mirror as they stand after the command.
    always_comb begin
        for (int k = 0; k < mdss_pkg::BYTES_MAX; k++) begin
            n_list[k] = 8'h00;
        end
        n_cnt   = '0;
        n_peak  = r_peak;
        n_level = r_level;
        unique case (i_in.command)
            mdss_pkg::CMD_GLYPH: begin
                if (i_in.digit <= mdss_pkg::DIGIT_MAX) begin
                    n_list[0] = mdss_pkg::ADDR_BASE | {5'b0, i_in.digit[2:0]};
                    for (int r = 0; r < mdss_pkg::ROWS_PER_GLYPH; r++) begin
                        n_list[r+1] = {3'b000, w_rows[r]};
                    end
                    n_cnt = (mdss_pkg::LIST_AW+1)'(mdss_pkg::ROWS_PER_GLYPH + 1);
                end else begin
                    for (int r = 0; r < mdss_pkg::ROWS_PER_GLYPH; r++) begin
                        n_list[r] = {3'b000, w_rows[r]};
                    end
                    n_cnt = (mdss_pkg::LIST_AW+1)'(mdss_pkg::ROWS_PER_GLYPH);
                end
            end
            mdss_pkg::CMD_BRIGHT: begin
                n_level   = ~i_in.brightness[mdss_pkg::LEVEL_W-1:0];
                n_list[0] = mdss_pkg::ctrl_byte(1'b0, r_peak, n_level);
                n_cnt     = (mdss_pkg::LIST_AW+1)'(1);
            end
            mdss_pkg::CMD_PEAK: begin
                n_peak    = i_in.low_peak;
                n_list[0] = mdss_pkg::ctrl_byte(1'b0, n_peak, r_level);
                n_cnt     = (mdss_pkg::LIST_AW+1)'(1);
            end
            mdss_pkg::CMD_CLEAR: begin
                n_list[0] = mdss_pkg::ctrl_byte(1'b1, r_peak, r_level);
                n_list[1] = mdss_pkg::ctrl_byte(1'b0, r_peak, r_level);
                n_cnt     = (mdss_pkg::LIST_AW+1)'(2);
            end
            mdss_pkg::CMD_RESET: begin
                n_peak    = i_init.low_peak;
                n_level   = ~i_init.bright;
                n_list[0] = mdss_pkg::ctrl_byte(1'b0, n_peak, '0);
                n_list[1] = mdss_pkg::ctrl_byte(1'b0, n_peak, n_level);
                n_cnt     = (mdss_pkg::LIST_AW+1)'(2);
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_peak     <= mdss_pkg::INIT_PEAK_RST;
            r_level    <= ~mdss_pkg::INIT_BRIGHT_RST;
        end else if (w_accept) begin
            r_busy     <= (n_cnt != '0);
            r_idx      <= '0;
            r_last_idx <= mdss_pkg::LIST_AW'(n_cnt - 1'b1);
            r_peak     <= n_peak;
            r_level    <= n_level;
        end else if (o_push) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_list <= n_list;
        end
    end

endmodule

FILE: rtl/mdss_back.sv
// Serializer: shifts queued bytes out one bit per transfer, LSB first.
`timescale 1ns / 1ps
`include "matrix_display_serial_command_sender_top_macros.svh"
module mdss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mdss_pkg::t_byte_entry i_entry,
    input  mdss_pkg::t_q_status   i_qstat,
    output logic                  o_pop,
    mdss_out_if.source            o_out
);
    logic                           r_active;
    logic [2:0]                     r_bit;
    logic [7:0]                     r_shift;
    logic                           r_last;
    logic [mdss_pkg::LEVEL_W-1:0]   r_level;
    logic                           r_peak;
    logic                           w_xfer;
    logic                           w_end;
    logic                           w_byte_done;

    assign w_end       = (r_bit == 3'd7);
    assign w_xfer      = r_active && o_out.ready;
    assign w_byte_done = w_xfer && w_end;
    assign o_pop       = !i_qstat.empty && (!r_active || w_byte_done);

    assign o_out.valid     = r_active;
    assign o_out.data_bit  = r_shift[0];
    assign o_out.byte_end  = w_end;
    assign o_out.last      = r_last && w_end;
    assign o_out.level_now = r_level;
    assign o_out.peak_now  = r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_bit    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_bit    <= '0;
        end else if (w_byte_done) begin
            r_active <= 1'b0;
            r_bit    <= '0;
        end else if (w_xfer) begin
            r_bit <= r_bit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_entry.data;
            r_last  <= i_entry.last;
            r_level <= i_entry.level;
            r_peak  <= i_entry.peak;
        end else if (w_xfer) begin
            r_shift <= {1'b0, r_shift[7:1]};
        end
    end

    `MDSS_ASSERT_NXT(a_load_starts, o_pop, r_active && (r_bit == 3'd0),
                     "loaded byte does not start at bit zero")
    `MDSS_ASSERT_IMP(a_bit_needs_active, r_bit != 3'd0, r_active,
                     "bit counter running while idle")
    `MDSS_ASSERT_NXT(a_done_goes_idle, w_byte_done && !o_pop, !r_active,
                     "serializer stays busy after final bit")

endmodule

FILE: rtl/matrix_display_serial_command_sender_top.sv
// Throughput: one serial bit per cycle while o_out.ready is high and a byte waits;
// a glyph write yields 64 bits (56 without the address byte), a control command
// 8 or 16; the bit serializer sets this pace.
// The next command is taken once the front end has queued every byte of the last.
// Reset (i_rst_n low, synchronous): queue and serializer empty, mirror at clear off,
// peak 0, brightness 7; initial brightness 7 and initial peak 0.
`timescale 1ns / 1ps
module matrix_display_serial_command_sender_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdss_in_if.sink     i_in,
    mdss_cfg_if.sink    i_cfg,
    mdss_out_if.source  o_out
);
    // Initial values loaded by the reset command.
    mdss_pkg::t_init_cfg    r_init;

    // Front end to queue, queue to serializer.
    mdss_pkg::t_byte_entry  w_push_entry;
    mdss_pkg::t_byte_entry  w_head_entry;
    mdss_pkg::t_q_status    w_qstat;
    logic                   w_push;
    logic                   w_pop;

    // Configuration is always ready; a transfer updates one initial value.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init.bright   <= mdss_pkg::INIT_BRIGHT_RST;
            r_init.low_peak <= mdss_pkg::INIT_PEAK_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mdss_pkg::REG_INIT_BRIGHT: begin
                    r_init.bright <= i_cfg.data[mdss_pkg::LEVEL_W-1:0];
                end
                mdss_pkg::REG_INIT_PEAK: begin
                    r_init.low_peak <= i_cfg.data[0];
                end
                default: begin
                    r_init <= r_init;
                end
            endcase
        end
    end

    // Front end: decode the command, update the control mirror, then push its bytes,
    // one per cycle while the queue has room, with the readback values they must carry.
    mdss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_init  (r_init),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    // Queue: lets the front end take the next command while bits still drain.
    mdss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_data  (w_head_entry),
        .o_stat  (w_qstat)
    );

    // Serializer: hold each bit until its transfer, advance LSB first, and
    // flag the eighth bit of a byte and the final bit of a command.
    mdss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (w_head_entry),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
